// ===== hdl/chc_pkg.sv =====
// ----------------------------------------------------------------------------
// Compass heading package
// Shared constants and the tangent table of the compass heading block.
// ----------------------------------------------------------------------------
package chc_pkg;

   // Number of entries in the tangent table, and the index bits it needs.
   localparam int TAN_ENTRIES  = 45;
   localparam int TAN_IDX_BITS = $clog2(TAN_ENTRIES);

   // Default width of the magnetometer samples that the block actually uses.
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed field widths of the transactions.
   localparam int FIELD_BITS   = 16;
   localparam int HEADING_BITS = 8;
   localparam int SCALE_BITS   = 16;

   // Heading arithmetic, in 2-degree units.
   localparam int HEADING_SPAN = 180;
   localparam int QUARTER_SPAN = 90;

   // The x/y scale is kept in hundredths.
   localparam int SCALE_GAIN = 100;

   // Entries of the tangent table, one per 2-degree step, strictly increasing.
   function automatic logic [15:0] tan_value(input logic [TAN_IDX_BITS-1:0] idx);
      logic [15:0] val;
      case (idx)
         6'd0:  val = 16'd2;
         6'd1:  val = 16'd5;
         6'd2:  val = 16'd9;
         6'd3:  val = 16'd12;
         6'd4:  val = 16'd16;
         6'd5:  val = 16'd19;
         6'd6:  val = 16'd23;
         6'd7:  val = 16'd27;
         6'd8:  val = 16'd31;
         6'd9:  val = 16'd34;
         6'd10: val = 16'd38;
         6'd11: val = 16'd42;
         6'd12: val = 16'd47;
         6'd13: val = 16'd51;
         6'd14: val = 16'd55;
         6'd15: val = 16'd60;
         6'd16: val = 16'd65;
         6'd17: val = 16'd70;
         6'd18: val = 16'd75;
         6'd19: val = 16'd81;
         6'd20: val = 16'd87;
         6'd21: val = 16'd93;
         6'd22: val = 16'd100;
         6'd23: val = 16'd107;
         6'd24: val = 16'd115;
         6'd25: val = 16'd123;
         6'd26: val = 16'd133;
         6'd27: val = 16'd143;
         6'd28: val = 16'd154;
         6'd29: val = 16'd166;
         6'd30: val = 16'd180;
         6'd31: val = 16'd196;
         6'd32: val = 16'd214;
         6'd33: val = 16'd236;
         6'd34: val = 16'd261;
         6'd35: val = 16'd290;
         6'd36: val = 16'd327;
         6'd37: val = 16'd373;
         6'd38: val = 16'd433;
         6'd39: val = 16'd514;
         6'd40: val = 16'd631;
         6'd41: val = 16'd814;
         6'd42: val = 16'd1143;
         6'd43: val = 16'd1908;
         6'd44: val = 16'd5729;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/chc_if.sv =====
// ----------------------------------------------------------------------------
// Compass heading channels
// Valid/ready channels for magnetometer samples and heading results.
// ----------------------------------------------------------------------------
interface chc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [chc_pkg::FIELD_BITS-1:0] field_x;
   logic signed [chc_pkg::FIELD_BITS-1:0] field_y;
   logic signed [chc_pkg::FIELD_BITS-1:0] field_z;

   modport source (output valid, output field_x, output field_y, output field_z,
                   input ready);
   modport sink   (input valid, input field_x, input field_y, input field_z,
                   output ready);
endinterface

interface chc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [chc_pkg::HEADING_BITS-1:0]  heading_smoothed;
   logic [chc_pkg::HEADING_BITS-1:0]  heading_raw;
   logic [chc_pkg::SCALE_BITS-1:0]    axis_scale;

   modport source (output valid, output heading_smoothed, output heading_raw,
                   output axis_scale, input ready);
   modport sink   (input valid, input heading_smoothed, input heading_raw,
                   input axis_scale, output ready);
endinterface

// ===== hdl/compass_heading_with_hard_iron_cal.sv =====
// ----------------------------------------------------------------------------
// Compass heading with hard-iron calibration
// Turns x,y,z magnetometer samples into a smoothed compass heading.
// ----------------------------------------------------------------------------
// Each request transaction carries one x,y,z magnetometer sample and produces
// exactly one response transaction. The block works on one sample at a time
// and drops req ready after the accepting cycle until the result has been
// written to the response register, which then waits for the consumer while
// the next sample can already be taken; a response still held by the consumer
// stalls the block. One shared subtract-and-compare unit runs the 23-step
// restoring division for the scale, when it is recomputed, the 16-step
// division for the y/x ratio and up to six steps of a binary search through
// the 45-entry tangent table; both are skipped when the centred x is zero.
// Only the low SAMPLE_BITS bits of each field are used, sign-extended.
// Per-axis peaks start at zero, and the offsets are their midpoints truncated
// toward zero. The heading is reported in 2-degree units; the smoothed heading
// is the average of the kept heading and this sample's heading, turned half a
// circle when the two lie half a circle or more apart. The z axis is tracked
// but drives no output.
// ----------------------------------------------------------------------------
module compass_heading_with_hard_iron_cal #(
   parameter int SAMPLE_BITS = chc_pkg::SAMPLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   chc_req_if.sink    req_chan,
   chc_rsp_if.source  rsp_chan
);

   // Dividend width of the scale division: a 16-bit difference times 100.
   localparam int DivBits = chc_pkg::SCALE_BITS + 7;
   localparam int CntBits = $clog2(DivBits);
   localparam int IdxBits = chc_pkg::TAN_IDX_BITS;
   localparam int HBits   = chc_pkg::HEADING_BITS;

   // The sequencer steps through the work of one sample.
   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_TRACK     = 9'b000000010,
      ST_CENTER    = 9'b000000100,
      ST_SCALE_MUL = 9'b000001000,
      ST_SCALE_DIV = 9'b000010000,
      ST_RATIO_MUL = 9'b000100000,
      ST_RATIO_DIV = 9'b001000000,
      ST_SEARCH    = 9'b010000000,
      ST_HEADING   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Latched sample.
   logic signed [SAMPLE_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;

   // Per-axis peaks.
   logic signed [SAMPLE_BITS-1:0] xh_ff, xh_in, xl_ff, xl_in;
   logic signed [SAMPLE_BITS-1:0] yh_ff, yh_in, yl_ff, yl_in;
   logic signed [SAMPLE_BITS-1:0] zh_ff, zh_in, zl_ff, zl_in;

   logic [chc_pkg::SCALE_BITS-1:0] scale_ff, scale_in;
   logic [HBits-1:0]               kept_ff, kept_in;

   // Centred magnitudes and their signs.
   logic [15:0] ax_ff, ax_in, ay_ff, ay_in;
   logic        cx_neg_ff, cx_neg_in, cy_neg_ff, cy_neg_in;

   // Shared divider datapath.
   logic [DivBits-1:0] quot_ff, quot_in;
   logic [15:0]        rem_ff, rem_in;
   logic [15:0]        dvsr_ff, dvsr_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;

   // Binary search bounds; lo holds the table index when the search ends.
   logic [IdxBits-1:0] lo_ff, lo_in, hi_ff, hi_in;

   // Response register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [HBits-1:0] rsp_smooth_ff, rsp_smooth_in, rsp_raw_ff, rsp_raw_in;
   logic [chc_pkg::SCALE_BITS-1:0] rsp_scale_ff, rsp_scale_in;

   // ------------------------------------------------------------------------
   // Offsets and centred values, from the peaks that the track step left.
   // The midpoint rounds toward zero, so a negative odd sum gets one added
   // before the arithmetic shift.
   // ------------------------------------------------------------------------
   logic signed [16:0] xsum, ysum, xrnd, yrnd, xoff, yoff;
   logic signed [16:0] dx17, dy17, cx17, cy17;
   logic [15:0]        cx16, cy16;
   logic               scale_go;

   assign xsum = 17'(xh_ff) + 17'(xl_ff);
   assign ysum = 17'(yh_ff) + 17'(yl_ff);
   assign xrnd = xsum + $signed({16'b0, xsum[16]});
   assign yrnd = ysum + $signed({16'b0, ysum[16]});
   assign xoff = xrnd >>> 1;
   assign yoff = yrnd >>> 1;
   assign dx17 = 17'(xh_ff) - xoff;
   assign dy17 = 17'(yh_ff) - yoff;
   assign cx17 = 17'(sx_ff) - xoff;
   assign cy17 = 17'(sy_ff) - yoff;
   assign cx16 = cx17[15:0];
   assign cy16 = cy17[15:0];

   // The scale is only recomputed when both maxima lie above their offsets.
   assign scale_go = (dx17 > 17'sd0) && (dy17 > 17'sd0) && (dy17[15:0] != 16'd0);

   // ------------------------------------------------------------------------
   // Shared subtract-and-compare unit. A borrow means the first operand is
   // smaller: in a division step the remainder is kept, in the search the
   // ratio lies below the table entry.
   // ------------------------------------------------------------------------
   logic [IdxBits:0]   mid_sum;
   logic [IdxBits-1:0] mid;
   logic [16:0]        rshift, sub_a, sub_b;
   logic [17:0]        diff;
   logic               borrow;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IdxBits:1];
   assign rshift  = {rem_ff, quot_ff[DivBits-1]};

   always_comb begin
      if (state_ff == ST_SEARCH) begin
         sub_a = {1'b0, quot_ff[15:0]};
         sub_b = {1'b0, chc_pkg::tan_value(mid)};
      end else begin
         sub_a = rshift;
         sub_b = {1'b0, dvsr_ff};
      end
   end

   assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow = diff[17];

   // ------------------------------------------------------------------------
   // Raw heading from the table index and the quadrant, then the smoothing
   // step with its wrap rule.
   // ------------------------------------------------------------------------
   logic [HBits-1:0] idx8, raw;
   logic [HBits:0]   sum9, half9, adj9, raw_plus, kept_plus;
   logic             wrap;

   assign idx8 = HBits'(lo_ff);

   always_comb begin
      if (!cx_neg_ff) begin
         raw = cy_neg_ff ? idx8 : HBits'(chc_pkg::HEADING_SPAN) - idx8;
      end else begin
         raw = cy_neg_ff ? HBits'(chc_pkg::QUARTER_SPAN) - idx8
                         : HBits'(chc_pkg::QUARTER_SPAN) + idx8;
      end
   end

   assign sum9      = {1'b0, kept_ff} + {1'b0, raw};
   assign half9     = {1'b0, sum9[HBits:1]};
   assign raw_plus  = {1'b0, raw} + (HBits+1)'(chc_pkg::QUARTER_SPAN);
   assign kept_plus = {1'b0, kept_ff} + (HBits+1)'(chc_pkg::QUARTER_SPAN);
   assign wrap      = ({1'b0, kept_ff} >= raw_plus) || (kept_plus <= {1'b0, raw});

   always_comb begin
      adj9 = half9 + (HBits+1)'(chc_pkg::QUARTER_SPAN);
      if (adj9 >= (HBits+1)'(chc_pkg::HEADING_SPAN)) begin
         adj9 = adj9 - (HBits+1)'(chc_pkg::HEADING_SPAN);
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer and next-state values.
   // ------------------------------------------------------------------------
   logic [15:0]  ratio_prod;
   logic         out_free;

   assign ratio_prod = ay_ff * scale_ff;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sz_in         = sz_ff;
      xh_in         = xh_ff;
      xl_in         = xl_ff;
      yh_in         = yh_ff;
      yl_in         = yl_ff;
      zh_in         = zh_ff;
      zl_in         = zl_ff;
      scale_in      = scale_ff;
      kept_in       = kept_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      cx_neg_in     = cx_neg_ff;
      cy_neg_in     = cy_neg_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      dvsr_in       = dvsr_ff;
      cnt_in        = cnt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_smooth_in = rsp_smooth_ff;
      rsp_raw_in    = rsp_raw_ff;
      rsp_scale_in  = rsp_scale_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sx_in    = req_chan.field_x[SAMPLE_BITS-1:0];
               sy_in    = req_chan.field_y[SAMPLE_BITS-1:0];
               sz_in    = req_chan.field_z[SAMPLE_BITS-1:0];
               state_in = ST_TRACK;
            end
         end
         ST_TRACK: begin
            // A new maximum wins; only otherwise can the minimum move.
            if (sx_ff > xh_ff) begin
               xh_in = sx_ff;
            end else if (sx_ff < xl_ff) begin
               xl_in = sx_ff;
            end
            if (sy_ff > yh_ff) begin
               yh_in = sy_ff;
            end else if (sy_ff < yl_ff) begin
               yl_in = sy_ff;
            end
            if (sz_ff > zh_ff) begin
               zh_in = sz_ff;
            end else if (sz_ff < zl_ff) begin
               zl_in = sz_ff;
            end
            state_in = ST_CENTER;
         end
         ST_CENTER: begin
            cx_neg_in = cx16[15];
            cy_neg_in = cy16[15];
            ax_in     = cx16[15] ? 16'(-cx16) : cx16;
            ay_in     = cy16[15] ? 16'(-cy16) : cy16;
            quot_in   = DivBits'(dx17[15:0]);
            dvsr_in   = dy17[15:0];
            state_in  = scale_go ? ST_SCALE_MUL : ST_RATIO_MUL;
         end
         ST_SCALE_MUL: begin
            quot_in  = {7'b0, quot_ff[15:0]} * DivBits'(chc_pkg::SCALE_GAIN);
            rem_in   = 16'd0;
            cnt_in   = CntBits'(DivBits - 1);
            state_in = ST_SCALE_DIV;
         end
         ST_SCALE_DIV: begin
            rem_in  = borrow ? rshift[15:0] : diff[15:0];
            quot_in = {quot_ff[DivBits-2:0], !borrow};
            cnt_in  = cnt_ff - CntBits'(1);
            if (cnt_ff == '0) begin
               // The scale is kept modulo 2^16.
               scale_in = quot_in[15:0];
               state_in = ST_RATIO_MUL;
            end
         end
         ST_RATIO_MUL: begin
            // The y magnitude times the scale, modulo 2^16, sits in the top
            // bits so that 16 steps leave the quotient in the low bits.
            quot_in = {ratio_prod, 7'b0};
            rem_in  = 16'd0;
            dvsr_in = ax_ff;
            cnt_in  = CntBits'(15);
            lo_in   = '0;
            hi_in   = IdxBits'(chc_pkg::TAN_ENTRIES);
            if (ax_ff == 16'd0) begin
               // Zero centred x points straight along the y axis.
               lo_in    = IdxBits'(chc_pkg::TAN_ENTRIES);
               state_in = ST_HEADING;
            end else begin
               state_in = ST_RATIO_DIV;
            end
         end
         ST_RATIO_DIV: begin
            rem_in  = borrow ? rshift[15:0] : diff[15:0];
            quot_in = {quot_ff[DivBits-2:0], !borrow};
            cnt_in  = cnt_ff - CntBits'(1);
            if (cnt_ff == '0) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // Find the first entry above the ratio; none gives the table size.
            if (lo_ff < hi_ff) begin
               if (borrow) begin
                  hi_in = mid;
               end else begin
                  lo_in = mid + IdxBits'(1);
               end
            end else begin
               state_in = ST_HEADING;
            end
         end
         ST_HEADING: begin
            if (out_free) begin
               kept_in       = wrap ? adj9[HBits-1:0] : half9[HBits-1:0];
               rsp_valid_in  = 1'b1;
               rsp_smooth_in = wrap ? adj9[HBits-1:0] : half9[HBits-1:0];
               rsp_raw_in    = raw;
               rsp_scale_in  = scale_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         xh_ff        <= '0;
         xl_ff        <= '0;
         yh_ff        <= '0;
         yl_ff        <= '0;
         zh_ff        <= '0;
         zl_ff        <= '0;
         scale_ff     <= '0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         xh_ff        <= xh_in;
         xl_ff        <= xl_in;
         yh_ff        <= yh_in;
         yl_ff        <= yl_in;
         zh_ff        <= zh_in;
         zl_ff        <= zl_in;
         scale_ff     <= scale_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      sz_ff         <= sz_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      cx_neg_ff     <= cx_neg_in;
      cy_neg_ff     <= cy_neg_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      dvsr_ff       <= dvsr_in;
      cnt_ff        <= cnt_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_smooth_ff <= rsp_smooth_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_scale_ff  <= rsp_scale_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.heading_smoothed = rsp_smooth_ff;
   assign rsp_chan.heading_raw      = rsp_raw_ff;
   assign rsp_chan.axis_scale       = rsp_scale_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // Peaks start at zero and only move outward, so max never falls below min.
   a_peaks_ordered: assert property (@(posedge clock) disable iff (reset)
      (xh_ff >= xl_ff) && (yh_ff >= yl_ff) && (zh_ff >= zl_ff))
      else $error("axis maximum below minimum");

   // The kept heading always stays within a full circle.
   a_kept_range: assert property (@(posedge clock) disable iff (reset)
      kept_ff < HBits'(chc_pkg::HEADING_SPAN))
      else $error("kept heading out of range");

   // The search bounds never pass the table size.
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |->
         (lo_ff <= IdxBits'(chc_pkg::TAN_ENTRIES)) && (lo_ff <= hi_ff + IdxBits'(0)))
      else $error("search bounds out of range");

   // A new response only appears after the heading step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HEADING))
      else $error("response raised outside the heading step");

   // An accepted sample keeps the block busy on the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_TRACK))
      else $error("sample accepted without tracking step");

endmodule
